// ===== rtl/core/aabb_iou_pkg.sv =====
package aabb_iou_pkg;

  localparam int COORD_W = 16;             // signed Q12.4 edge
  localparam int DIFF_W  = COORD_W + 1;    // edge difference, width or height
  localparam int PROD_W  = 2 * DIFF_W;     // area in units of 1/256
  localparam int UNI_W   = PROD_W + 2;     // union: two areas less the overlap
  localparam int DIV_W   = UNI_W - 1;      // positive union, divider remainder
  localparam int RATIO_W = 16;             // unsigned Q0.16
  localparam int STEP_W  = 4;              // counts the RATIO_W quotient steps
  localparam int CNT_W   = 7;              // reference count, 0..127
  localparam int SLOT_W  = 6;
  localparam int ROW_W   = 16;

  localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCORE = 1'b1
  } op_t;

  typedef struct packed {
    logic                      operation;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] box_x_low;
    logic signed [COORD_W-1:0] box_y_low;
    logic signed [COORD_W-1:0] box_x_high;
    logic signed [COORD_W-1:0] box_y_high;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   candidate_index;
    logic [SLOT_W-1:0]  reference_index;
    logic [RATIO_W-1:0] overlap_ratio;
    logic               degenerate;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== rtl/core/axis_aligned_box_iou_matrix.sv =====
// Write items leave busy low, and the next item may follow at once.
// A score item walks N = min(reference_count, MAX_REFERENCES) reference slots:
// per reference a table read, two passes through the shared 17x17 multiplier, a union
// add, a check, 16 restoring divide steps and the emit; a degenerate or saturated ratio
// skips the divider. Busy holds off new items until the row is done; the receiver cannot stall.
// Synchronous active-low reset clears control, the count and the row counter, not the table.
module axis_aligned_box_iou_matrix #(
  parameter int MAX_REFERENCES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  aabb_iou_pkg::in_item_t     in_item,
  output logic                       out_valid,
  output aabb_iou_pkg::out_item_t    out_item,
  input  logic                       cfg_we,
  input  logic [aabb_iou_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int DW = aabb_iou_pkg::DIFF_W;
  localparam int PW = aabb_iou_pkg::PROD_W;
  localparam int UW = aabb_iou_pkg::UNI_W;
  localparam int CW = aabb_iou_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REFERENCES);

  // Sequencer: one pass READ..EMIT per reference slot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CAND  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_AREF  = 9'b000001000,
    ST_INTER = 9'b000010000,
    ST_UNION = 9'b000100000,
    ST_CHECK = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                      ref_count_r;
  logic [CW-1:0]                      n_r;
  logic [aabb_iou_pkg::ROW_W-1:0]     cand_cnt_r;
  logic [aabb_iou_pkg::ROW_W-1:0]     row_r;
  logic [AW-1:0]                      k_r;
  logic [aabb_iou_pkg::STEP_W-1:0]    step_r;
  aabb_iou_pkg::in_item_t             cand_r;

  // Reference table: four packed edges per slot, no reset.
  aabb_iou_pkg::in_item_t             ref_mem [MAX_REFERENCES];
  aabb_iou_pkg::in_item_t             ref_rd_r;

  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] area_c_r;
  logic signed [PW-1:0] aref_r;
  logic signed [PW-1:0] inter_r;
  logic signed [UW-1:0] uni_r;
  logic signed [DW-1:0] w_r, h_r;
  logic                 degen_r, sat_r;

  logic                 out_valid_r;
  aabb_iou_pkg::out_item_t out_item_r;

  logic accept;
  logic last_ref;
  logic degen_now, sat_now;
  aabb_iou_pkg::div_ctrl_t div_ctrl;
  logic [aabb_iou_pkg::RATIO_W-1:0] quot;

  // Overlap edges of candidate and fetched reference.
  logic signed [aabb_iou_pkg::COORD_W-1:0] ix1, iy1, ix2, iy2;
  logic signed [DW-1:0] w_raw, h_raw;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign last_ref = ((CW'(k_r) + CW'(1)) == n_r);

  assign ix1 = (cand_r.box_x_low  > ref_rd_r.box_x_low)  ? cand_r.box_x_low  : ref_rd_r.box_x_low;
  assign iy1 = (cand_r.box_y_low  > ref_rd_r.box_y_low)  ? cand_r.box_y_low  : ref_rd_r.box_y_low;
  assign ix2 = (cand_r.box_x_high < ref_rd_r.box_x_high) ? cand_r.box_x_high : ref_rd_r.box_x_high;
  assign iy2 = (cand_r.box_y_high < ref_rd_r.box_y_high) ? cand_r.box_y_high : ref_rd_r.box_y_high;
  assign w_raw = DW'(ix2) - DW'(ix1);
  assign h_raw = DW'(iy2) - DW'(iy1);

  assign degen_now = uni_r[UW-1] || (uni_r == '0);
  assign sat_now   = UW'($unsigned(inter_r)) >= $unsigned(uni_r);

  // Shared multiplier operand select: candidate area, reference area, overlap area.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CAND: begin
        mul_a = DW'(cand_r.box_x_high) - DW'(cand_r.box_x_low);
        mul_b = DW'(cand_r.box_y_high) - DW'(cand_r.box_y_low);
      end
      ST_AREF: begin
        mul_a = DW'(ref_rd_r.box_x_high) - DW'(ref_rd_r.box_x_low);
        mul_b = DW'(ref_rd_r.box_y_high) - DW'(ref_rd_r.box_y_low);
      end
      ST_INTER: begin
        mul_a = w_r;
        mul_b = h_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (accept && (in_item.operation == aabb_iou_pkg::OP_SCORE)) state_nxt = ST_CAND;
      ST_CAND:  state_nxt = (n_r == '0) ? ST_IDLE : ST_READ;
      ST_READ:  state_nxt = ST_AREF;
      ST_AREF:  state_nxt = ST_INTER;
      ST_INTER: state_nxt = ST_UNION;
      ST_UNION: state_nxt = ST_CHECK;
      ST_CHECK: begin
        // Degenerate and saturated ratios skip the divider.
        if (degen_now || sat_now) begin
          state_nxt = ST_EMIT;
        end else begin
          div_ctrl.load = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        if (step_r == '1) state_nxt = ST_EMIT;
      end
      ST_EMIT:  state_nxt = last_ref ? ST_IDLE : ST_READ;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_count_r <= '0;
      cand_cnt_r  <= '0;
      n_r         <= '0;
      k_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EMIT);
      if (cfg_we) ref_count_r <= cfg_wdata;
      if (accept && (in_item.operation == aabb_iou_pkg::OP_SCORE)) begin
        // Clamp the count to the table depth; advance the row counter.
        n_r        <= (ref_count_r > MAX_CNT) ? MAX_CNT : ref_count_r;
        cand_cnt_r <= cand_cnt_r + aabb_iou_pkg::ROW_W'(1);
        k_r        <= '0;
      end
      if (state_r == ST_CHECK) step_r <= '0;
      else if (state_r == ST_DIV) step_r <= step_r + aabb_iou_pkg::STEP_W'(1);
      if (state_r == ST_EMIT) k_r <= k_r + AW'(1);
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (accept && (in_item.operation == aabb_iou_pkg::OP_WRITE)
        && (CW'(in_item.slot) < MAX_CNT)) begin
      ref_mem[in_item.slot[AW-1:0]] <= in_item;
    end
    if (state_r == ST_READ) ref_rd_r <= ref_mem[k_r];
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      cand_r <= in_item;
      row_r  <= cand_cnt_r;
    end
    // Candidate area leaves the multiplier as the first read issues.
    if ((state_r == ST_READ) && (k_r == '0)) area_c_r <= prod_r;
    if (state_r == ST_AREF) begin
      w_r <= w_raw[DW-1] ? '0 : w_raw;
      h_r <= h_raw[DW-1] ? '0 : h_raw;
    end
    if (state_r == ST_INTER) aref_r <= prod_r;
    if (state_r == ST_UNION) begin
      inter_r <= prod_r;
      uni_r   <= UW'(area_c_r) + UW'(aref_r) - UW'(prod_r);
    end
    if (state_r == ST_CHECK) begin
      degen_r <= degen_now;
      sat_r   <= sat_now;
    end
    if (state_r == ST_EMIT) begin
      out_item_r.candidate_index <= row_r;
      out_item_r.reference_index <= aabb_iou_pkg::SLOT_W'(k_r);
      out_item_r.overlap_ratio   <= degen_r ? '0 : (sat_r ? aabb_iou_pkg::RATIO_SAT : quot);
      out_item_r.degenerate      <= degen_r;
      out_item_r.last            <= last_ref;
    end
  end

  aabb_iou_div u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (aabb_iou_pkg::DIV_W'($unsigned(inter_r))),
    .den  (uni_r[aabb_iou_pkg::DIV_W-1:0]),
    .quot (quot)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Results are spaced by a full reference pass.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held for two cycles");

  // The row ends with the sequencer back in idle, and not before.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last == !busy)) else $error("last mark out of step with sequencer");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |-> (out_item.overlap_ratio == '0))
    else $error("degenerate result with nonzero ratio");

  a_ref_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CW'(out_item.reference_index) < n_r))
    else $error("reference index beyond count in use");

endmodule

// ===== rtl/core/aabb_iou_div.sv =====
// Restoring divider, one quotient bit per step; numerator must be below den.
module aabb_iou_div (
  input  logic                                clk,
  input  aabb_iou_pkg::div_ctrl_t             ctrl,
  input  logic [aabb_iou_pkg::DIV_W-1:0]      num,
  input  logic [aabb_iou_pkg::DIV_W-1:0]      den,
  output logic [aabb_iou_pkg::RATIO_W-1:0]    quot
);

  logic [aabb_iou_pkg::DIV_W-1:0]   rem_r;
  logic [aabb_iou_pkg::RATIO_W-1:0] quot_r;
  logic [aabb_iou_pkg::DIV_W:0]     shifted;
  logic [aabb_iou_pkg::DIV_W:0]     diff;
  logic                             fits;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r  <= num;
      quot_r <= '0;
    end else if (ctrl.step) begin
      rem_r  <= fits ? diff[aabb_iou_pkg::DIV_W-1:0] : shifted[aabb_iou_pkg::DIV_W-1:0];
      quot_r <= {quot_r[aabb_iou_pkg::RATIO_W-2:0], fits};
    end
  end

  assign quot = quot_r;

endmodule

// ===== tb/sv/axis_aligned_box_iou_matrix_tb.sv =====
module axis_aligned_box_iou_matrix_tb;

  localparam int TABLE_DEPTH   = 64;    // MAX_REFERENCES of the block under test
  localparam int SETTLE_CYCLES = 30;    // covers a count-zero score or a write still in flight
  localparam int STALL_LIMIT   = 2000;  // worst silent stretch is one result spacing plus a gap

  // One queued input transfer; drain_first makes the sender wait until the
  // block is empty before offering it.
  typedef struct {
    aabb_iou_pkg::in_item_t item;
    bit                     drain_first;
  } send_entry_t;

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                start     = 1'b0;
  logic                                busy;
  aabb_iou_pkg::in_item_t              in_item   = '0;
  logic                                out_valid;
  aabb_iou_pkg::out_item_t             out_item;
  logic                                cfg_we    = 1'b0;
  logic [aabb_iou_pkg::CNT_W-1:0]      cfg_wdata = '0;

  send_entry_t                         send_queue[$];      // items waiting to be offered
  aabb_iou_pkg::out_item_t             iou_expected[$];    // predicted results, oldest first
  aabb_iou_pkg::in_item_t              ref_boxes[TABLE_DEPTH];
  bit                                  slot_loaded[TABLE_DEPTH];
  logic [aabb_iou_pkg::CNT_W-1:0]      ref_count_model = '0;
  logic [aabb_iou_pkg::ROW_W-1:0]      row_model       = '0;
  int                                  gap_left        = 0;
  bit                                  gaps_on         = 1'b1;
  int                                  error_count     = 0;
  int                                  stall_cycles    = 0;

  axis_aligned_box_iou_matrix dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // IoU predictor. Edges are Q12.4, so widths and heights are exact integers in
  // 1/16 units and areas exact in 1/256 units; 64-bit math holds them all.
  // ---------------------------------------------------------------------------
  function automatic logic [aabb_iou_pkg::RATIO_W-1:0] iou_q16(
      input aabb_iou_pkg::in_item_t cand, input aabb_iou_pkg::in_item_t refb,
      output logic degen);
    longint cx1, cy1, cx2, cy2, rx1, ry1, rx2, ry2;
    longint ix1, iy1, ix2, iy2, w, h, overlap, area_c, area_r, union_area;
    cx1 = $signed(cand.box_x_low);
    cy1 = $signed(cand.box_y_low);
    cx2 = $signed(cand.box_x_high);
    cy2 = $signed(cand.box_y_high);
    rx1 = $signed(refb.box_x_low);
    ry1 = $signed(refb.box_y_low);
    rx2 = $signed(refb.box_x_high);
    ry2 = $signed(refb.box_y_high);
    ix1 = (cx1 > rx1) ? cx1 : rx1;
    iy1 = (cy1 > ry1) ? cy1 : ry1;
    ix2 = (cx2 < rx2) ? cx2 : rx2;
    iy2 = (cy2 < ry2) ? cy2 : ry2;
    // Clamp the overlap extent at zero; the box areas themselves are not clamped,
    // so a box inverted on one axis feeds a negative area into the union.
    w = (ix2 > ix1) ? ix2 - ix1 : 0;
    h = (iy2 > iy1) ? iy2 - iy1 : 0;
    overlap    = w * h;
    area_c     = (cx2 - cx1) * (cy2 - cy1);
    area_r     = (rx2 - rx1) * (ry2 - ry1);
    union_area = area_c + area_r - overlap;
    degen = 1'b0;
    if (union_area <= 0) begin
      degen = 1'b1;
      return '0;
    end
    if (overlap >= union_area)
      return aabb_iou_pkg::RATIO_SAT;
    // A 16-step restoring divide with num < den equals floor(num * 2^16 / den).
    return aabb_iou_pkg::RATIO_W'((overlap << aabb_iou_pkg::RATIO_W) / union_area);
  endfunction

  // Apply one accepted transfer: a write updates the table copy, a score
  // queues one expected result per reference slot in use.
  function automatic void predict_iou_row(input aabb_iou_pkg::in_item_t item);
    int                      n;
    aabb_iou_pkg::out_item_t r;
    if (item.operation == aabb_iou_pkg::OP_WRITE) begin
      ref_boxes[item.slot] = item;
      return;
    end
    n = (ref_count_model > TABLE_DEPTH) ? TABLE_DEPTH : ref_count_model;
    for (int k = 0; k < n; k++) begin
      r.candidate_index = row_model;
      r.reference_index = aabb_iou_pkg::SLOT_W'(k);
      r.overlap_ratio   = iou_q16(item, ref_boxes[k], r.degenerate);
      r.last            = (k == n - 1);
      iou_expected.insert(iou_expected.size(), r);
    end
    // The row counter advances even when the count is zero.
    row_model++;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [aabb_iou_pkg::ROW_W-1:0] want_v,
                                      input logic [aabb_iou_pkg::ROW_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic aabb_iou_pkg::in_item_t box_item(input aabb_iou_pkg::op_t op,
                                                      input int slot, input int xl,
                                                      input int yl, input int xh,
                                                      input int yh);
    aabb_iou_pkg::in_item_t it;
    it.operation  = op;
    it.slot       = aabb_iou_pkg::SLOT_W'(slot);
    it.box_x_low  = aabb_iou_pkg::COORD_W'(xl);
    it.box_y_low  = aabb_iou_pkg::COORD_W'(yl);
    it.box_x_high = aabb_iou_pkg::COORD_W'(xh);
    it.box_y_high = aabb_iou_pkg::COORD_W'(yh);
    return it;
  endfunction

  function automatic void queue_item(input aabb_iou_pkg::in_item_t item,
                                     input bit drain_first = 1'b0);
    send_entry_t e;
    e.item        = item;
    e.drain_first = drain_first;
    // Track loaded slots in generation order, which is also transfer order.
    if (item.operation == aabb_iou_pkg::OP_WRITE)
      slot_loaded[item.slot] = 1'b1;
    send_queue.insert(send_queue.size(), e);
  endfunction

  function automatic int edge_value();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic aabb_iou_pkg::in_item_t random_box(input aabb_iou_pkg::op_t op);
    int                     mode, xc, yc, hw, hh;
    aabb_iou_pkg::in_item_t it;
    mode = $urandom_range(0, 99);
    xc   = int'($urandom_range(0, 800)) - 400;
    yc   = int'($urandom_range(0, 800)) - 400;
    hw   = $urandom_range(1, 300);
    hh   = $urandom_range(1, 300);
    if (mode < 60) begin
      // Well-formed and clustered near the origin so most pairs overlap.
      it = box_item(op, 0, xc - hw, yc - hh, xc + hw, yc + hh);
    end else if (mode < 72) begin
      it = box_item(op, 0, xc + hw, yc + hh, xc - hw, yc - hh);   // inverted
    end else if (mode < 84) begin
      it = box_item(op, 0, int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    end else if (mode < 94) begin
      it = box_item(op, 0, edge_value(), edge_value(), edge_value(), edge_value());
    end else begin
      it = box_item(op, 0, xc, yc - hh, xc, yc + hh);              // zero width
    end
    it.slot = aabb_iou_pkg::SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    return it;
  endfunction

  // Wait until every queued item has been taken and every result has come,
  // then let a count-zero score or trailing write finish inside the block.
  task automatic wait_idle();
    while (send_queue.size() != 0 || start || busy || iou_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ref_count(input int value);
    @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_wdata       <= aabb_iou_pkg::CNT_W'(value);
    ref_count_model  = aabb_iou_pkg::CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One configuration setting: load any slot below the count that was never
  // written, then a random mix of writes and scores. The middle item waits
  // for the block to empty first.
  task automatic run_phase(input int count, input int n_items);
    aabb_iou_pkg::in_item_t it;
    int                     fill;
    wait_idle();
    set_ref_count(count);
    fill = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    for (int s = 0; s < fill; s++) begin
      if (!slot_loaded[s]) begin
        it      = random_box(aabb_iou_pkg::OP_WRITE);
        it.slot = aabb_iou_pkg::SLOT_W'(s);
        queue_item(it);
      end
    end
    for (int i = 0; i < n_items; i++) begin
      it = random_box(($urandom_range(0, 3) == 0) ? aabb_iou_pkg::OP_WRITE
                                                  : aabb_iou_pkg::OP_SCORE);
      queue_item(it, i == n_items / 2);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the head of send_queue, hold start until the transfer, and
  // insert random idle bursts between transfers.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic keep_start;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left  = 0;
    end else begin
      keep_start = start;
      if (start && !busy) begin
        predict_iou_row(send_queue[0].item);
        void'(send_queue.pop_front());
        keep_start = 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 9);
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      // Launch the next item unless idling or it must wait for an empty block.
      if (!keep_start && gap_left == 0 && send_queue.size() != 0 &&
          !(send_queue[0].drain_first && (busy || iou_expected.size() != 0))) begin
        in_item    <= send_queue[0].item;
        keep_start  = 1'b1;
      end
      start <= keep_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobed result is a transfer; match it to the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    aabb_iou_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (iou_expected.size() == 0) begin
        $error("unexpected result: candidate_index %0d reference_index %0d",
               out_item.candidate_index, out_item.reference_index);
        error_count++;
      end else begin
        want = iou_expected.pop_front();
        check_field("candidate_index", want.candidate_index, out_item.candidate_index);
        check_field("reference_index", want.reference_index, out_item.reference_index);
        check_field("overlap_ratio", want.overlap_ratio, out_item.overlap_ratio);
        check_field("degenerate", want.degenerate, out_item.degenerate);
        check_field("last", want.last, out_item.last);
      end
    end
  end

  // Count cycles with no transfer on either side; a hang ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_counts[11];
    phase_counts = '{1, 3, 8, 0, 2, 16, 5, 64, 127, 6, 12};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Count is zero out of reset: a score returns nothing but bumps the row.
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 0, 0, 16, 16));
    // Load a zero box, the full coordinate range, an inverted box, a plain box
    // and the top slot.
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 0, 0, 0, 0, 0));
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 1, -32768, -32768, 32767, 32767));
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 2, 100, 100, -100, -100));
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 3, 0, 0, 160, 160));
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 63, 32767, -32768, -32768, 32767));
    wait_idle();
    set_ref_count(4);
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 0, 0, 160, 160));     // identical: saturates
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 0, 0, 0, 0));         // zero union, slot 0
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, -32768, -32768, 32767, 32767));
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 80, 80, 240, 240));   // partial overlap
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 160, 0, 320, 160));   // edges touch
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 1000, 1000, 1200, 1200)); // disjoint
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 32767, 32767, -32768, -32768)); // inverted
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, -50, -50, 50, 50));
    queue_item(box_item(aabb_iou_pkg::OP_WRITE, 3, 10, 20, 300, 40));    // overwrite a used slot
    queue_item(box_item(aabb_iou_pkg::OP_SCORE, 0, 0, 0, 160, 160));

    // Random settings, including zero, the table size and the 7-bit maximum.
    // Keep full-table phases short since each score there walks every slot.
    foreach (phase_counts[p]) begin
      if (p == $size(phase_counts) - 1) begin
        wait_idle();
        gaps_on = 1'b0;   // drop idling for the closing stretch
      end
      run_phase(phase_counts[p], (phase_counts[p] >= TABLE_DEPTH) ? 8 : 24);
    end

    wait_idle();
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== axis_aligned_box_iou_matrix.f =====
rtl/core/aabb_iou_pkg.sv
rtl/core/aabb_iou_div.sv
rtl/core/axis_aligned_box_iou_matrix.sv
tb/sv/axis_aligned_box_iou_matrix_tb.sv
